@@ rtl/ird_pkg.sv @@
package ird_pkg;

  // timer ticks and frame geometry
  localparam int unsigned TickW    = 16;
  localparam int unsigned FrameW   = 32;
  localparam int unsigned BitCntW  = $clog2(FrameW);
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned QueueDepth = 2;

  typedef logic [TickW-1:0] tick_t;

  // fixed pause windows for start and repeat bursts, exclusive bounds
  localparam tick_t StartPauseMin  = 16'd4000;
  localparam tick_t StartPauseMax  = 16'd5000;
  localparam tick_t RepeatPauseMin = 16'd2000;
  localparam tick_t RepeatPauseMax = 16'd2500;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgBitPulseMin   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBitPulseMax   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgZeroPauseMin  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgZeroPauseMax  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOnePauseMin   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgOnePauseMax   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgStartPulseMin = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgStartPulseMax = 3'd7;

  typedef struct packed {
    tick_t bit_pulse_min;
    tick_t bit_pulse_max;
    tick_t zero_pause_min;
    tick_t zero_pause_max;
    tick_t one_pause_min;
    tick_t one_pause_max;
    tick_t start_pulse_min;
    tick_t start_pulse_max;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    bit_pulse_min:   16'd400,
    bit_pulse_max:   16'd700,
    zero_pause_min:  16'd400,
    zero_pause_max:  16'd700,
    one_pause_min:   16'd1500,
    one_pause_max:   16'd1900,
    start_pulse_min: 16'd8500,
    start_pulse_max: 16'd9500
  };

  // symbol decided by the front end
  typedef enum logic [2:0] {
    SymNone,
    SymStart,
    SymRepeat,
    SymOne,
    SymZero
  } sym_e;

  // one queued request for the back end
  typedef struct packed {
    logic ack;
    sym_e sym;
  } cmd_t;

  // ascii keys
  localparam logic [7:0] KeyS     = 8'h53;
  localparam logic [7:0] KeyW     = 8'h57;
  localparam logic [7:0] KeyT     = 8'h54;
  localparam logic [7:0] KeyMinus = 8'h2d;
  localparam logic [7:0] KeyPlus  = 8'h2b;
  localparam logic [7:0] KeyNone  = 8'h00;

  function automatic logic [7:0] key_of(logic [7:0] cmd);
    logic [7:0] key;
    unique case (cmd)
      8'd1:    key = KeyS;
      8'd2:    key = KeyW;
      8'd3:    key = KeyT;
      8'd4:    key = KeyMinus;
      8'd5:    key = KeyPlus;
      default: key = KeyNone;
    endcase
    return key;
  endfunction

endpackage

@@ rtl/ird_if.sv @@
interface ird_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] capture_time;
  logic        line_level;

  modport source (output valid, output op, output capture_time, output line_level,
                  input ready);
  modport sink (input valid, input op, input capture_time, input line_level,
                output ready);
endinterface

interface ird_res_if;
  logic        valid;
  logic        ready;
  logic        frame_ready;
  logic [15:0] address;
  logic [7:0]  command;
  logic [7:0]  key_code;

  modport source (output valid, output frame_ready, output address, output command,
                  output key_code, input ready);
  modport sink (input valid, input frame_ready, input address, input command,
                input key_code, output ready);
endinterface

@@ rtl/ird_front.sv @@
module ird_front import ird_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  accept_i,
  input  logic  op_i,
  input  tick_t capture_time_i,
  input  logic  line_level_i,
  output cmd_t  cmd_o
);

  tick_t last_edge_q, last_edge_d;
  tick_t pulse_q, pulse_d;
  tick_t delta;
  logic  bit_pulse, start_pulse;

  function automatic logic in_window(tick_t v, tick_t lo, tick_t hi);
    return (v > lo) && (v < hi);
  endfunction

  // time since last edge, wraps with the timer
  assign delta = capture_time_i - last_edge_q;

  assign bit_pulse   = in_window(pulse_q, cfg_i.bit_pulse_min, cfg_i.bit_pulse_max);
  assign start_pulse = in_window(pulse_q, cfg_i.start_pulse_min, cfg_i.start_pulse_max);

  // classify the pulse/pause pair on the edge that ends a pause
  always_comb begin
    cmd_o.ack = op_i;
    cmd_o.sym = SymNone;
    if (!op_i && !line_level_i) begin
      if (bit_pulse) begin
        if (in_window(delta, cfg_i.zero_pause_min, cfg_i.zero_pause_max)) begin
          cmd_o.sym = SymZero;
        end else if (in_window(delta, cfg_i.one_pause_min, cfg_i.one_pause_max)) begin
          cmd_o.sym = SymOne;
        end
      end else if (start_pulse) begin
        if (in_window(delta, StartPauseMin, StartPauseMax)) begin
          cmd_o.sym = SymStart;
        end else if (in_window(delta, RepeatPauseMin, RepeatPauseMax)) begin
          cmd_o.sym = SymRepeat;
        end
      end
    end
  end

  // edge timing state
  always_comb begin
    last_edge_d = last_edge_q;
    pulse_d     = pulse_q;
    if (accept_i && !op_i) begin
      last_edge_d = capture_time_i;
      if (line_level_i) begin
        pulse_d = delta;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q <= '0;
      pulse_q     <= '0;
    end else begin
      last_edge_q <= last_edge_d;
      pulse_q     <= pulse_d;
    end
  end

endmodule

@@ rtl/ird_fifo.sv @@
module ird_fifo import ird_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != CntW'(QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/ird_back.sv @@
module ird_back import ird_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        frame_ready_o,
  output logic [15:0] address_o,
  output logic [7:0]  command_o,
  output logic [7:0]  key_code_o
);

  localparam logic [1:0] StIdle     = 2'd0;
  localparam logic [1:0] StReceive  = 2'd1;
  localparam logic [1:0] StReceived = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic [FrameW-1:0] bits_q, bits_d;
  logic              pop, release_frame, show;
  logic [7:0]        key;

  logic              valid_q;
  logic              frame_ready_q, frame_ready_d;
  logic [15:0]       address_q, address_d;
  logic [7:0]        command_q, command_d;
  logic [7:0]        key_q;

  assign cmd_ready_o = !valid_q || res_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // receive sequencer
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    bits_d        = bits_q;
    key           = KeyNone;
    release_frame = 1'b0;
    if (cmd_i.ack) begin
      if (state_q == StReceived) begin
        key           = key_of(bits_q[23:16]);
        state_d       = StIdle;
        release_frame = 1'b1;
      end
    end else if (cmd_i.sym != SymNone && state_q != StReceived) begin
      if (state_q != StReceive) begin
        state_d = StIdle;
        if (cmd_i.sym == SymStart) begin
          cnt_d   = '0;
          state_d = StReceive;
        end
      end else if (cmd_i.sym == SymStart || cmd_i.sym == SymRepeat) begin
        cnt_d = '0;
      end else begin
        bits_d[cnt_q] = (cmd_i.sym == SymOne);
        cnt_d         = BitCntW'(cnt_q + 1'b1);
        if (cnt_q == BitCntW'(FrameW - 1)) begin
          // command byte against its inverse
          state_d = ((bits_d[23:16] ^ bits_d[31:24]) == 8'hff) ? StReceived : StIdle;
        end
      end
    end
  end

  // result fields
  always_comb begin
    frame_ready_d = (state_d == StReceived);
    show          = release_frame || frame_ready_d;
    address_d     = show ? {bits_d[7:0], bits_d[15:8]} : '0;
    command_d     = show ? bits_d[23:16] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      bits_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
        bits_q  <= bits_d;
        valid_q <= 1'b1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (pop) begin
      frame_ready_q <= frame_ready_d;
      address_q     <= address_d;
      command_q     <= command_d;
      key_q         <= key;
    end
  end

  assign res_valid_o   = valid_q;
  assign frame_ready_o = frame_ready_q;
  assign address_o     = address_q;
  assign command_o     = command_q;
  assign key_code_o    = key_q;

endmodule

@@ rtl/ir_remote_frame_decoder_core.sv @@
// infrared remote frame decoder, nec style
//
// req_i carries one request per line edge (op 0: capture time and level
// after the edge) or an acknowledge (op 1). res_o returns exactly one result
// per request, in order: frame_ready, the held address and command, and the
// key code on the acknowledge that releases a frame.
// a request is classified into the queue, then the receive sequencer moves
// it into the output register, where its result is valid. throughput: one
// request per cycle while res_o does not stall; the receive sequencer takes
// a queued request whenever its output register is free or being taken.
// when res_o stalls, the two-entry queue and the output register hold up
// to three results before req_i.ready drops; edge timing keeps running
// only as requests are accepted.
// reset clears the timing state, the receiver and the queue and loads the
// default timing windows. the cfg port writes one window register per
// cycle; write only while no request is in flight.
module ir_remote_frame_decoder_core import ird_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  tick_t              cfg_wdata_i,
  ird_req_if.sink            req_i,
  ird_res_if.source          res_o
);

  cfg_t cfg_q;
  cmd_t front_cmd, queue_cmd;
  logic queue_ready, queue_valid, back_ready, accept;

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBitPulseMin:   cfg_q.bit_pulse_min   <= cfg_wdata_i;
        CfgBitPulseMax:   cfg_q.bit_pulse_max   <= cfg_wdata_i;
        CfgZeroPauseMin:  cfg_q.zero_pause_min  <= cfg_wdata_i;
        CfgZeroPauseMax:  cfg_q.zero_pause_max  <= cfg_wdata_i;
        CfgOnePauseMin:   cfg_q.one_pause_min   <= cfg_wdata_i;
        CfgOnePauseMax:   cfg_q.one_pause_max   <= cfg_wdata_i;
        CfgStartPulseMin: cfg_q.start_pulse_min <= cfg_wdata_i;
        CfgStartPulseMax: cfg_q.start_pulse_max <= cfg_wdata_i;
      endcase
    end
  end

  assign req_i.ready = queue_ready;
  assign accept      = req_i.valid && queue_ready;

  // edge timing and symbol classification
  ird_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .op_i           (req_i.op),
    .capture_time_i (req_i.capture_time),
    .line_level_i   (req_i.line_level),
    .cmd_o          (front_cmd)
  );

  // decoupling queue
  ird_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (req_i.valid),
    .wr_ready_o (queue_ready),
    .wr_data_i  (front_cmd),
    .rd_valid_o (queue_valid),
    .rd_ready_i (back_ready),
    .rd_data_o  (queue_cmd)
  );

  // frame assembly and result register
  ird_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (queue_valid),
    .cmd_ready_o   (back_ready),
    .cmd_i         (queue_cmd),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .frame_ready_o (res_o.frame_ready),
    .address_o     (res_o.address),
    .command_o     (res_o.command),
    .key_code_o    (res_o.key_code)
  );

endmodule

@@ rtl/ird_checker.sv @@
module ird_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        frame_ready_i,
  input logic [15:0] address_i,
  input logic [7:0]  command_i,
  input logic [7:0]  key_code_i
);

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable(frame_ready_i) && $stable(address_i) && $stable(command_i) &&
      $stable(key_code_i))
    else $error("result fields changed while stalled");

  // a key comes only with a release of a frame carrying a mapped command
  a_key_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && key_code_i != 8'h00 |->
      !frame_ready_i && (command_i == 8'd1 || command_i == 8'd2 || command_i == 8'd3 ||
                         command_i == 8'd4 || command_i == 8'd5))
    else $error("key code without released frame");

endmodule

bind ir_remote_frame_decoder_core ird_props u_ird_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .frame_ready_i (res_o.frame_ready),
  .address_i     (res_o.address),
  .command_i     (res_o.command),
  .key_code_i    (res_o.key_code)
);

@@ verif/ird_tb_pkg.sv @@
package ird_tb_pkg;

  // request kinds on the req channel
  typedef enum logic {
    OpEdge = 1'b0,
    OpAck  = 1'b1
  } ird_op_e;

endpackage

@@ verif/ird_checker.sv @@
module ird_checker
  import ird_pkg::*;
  import ird_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  tick_t              cfg_wdata_i,
  ird_req_if                 req_i,
  ird_res_if                 res_i,
  output int                 err_cnt_o,
  output int                 in_flight_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    RxIdle,
    RxBusy,
    RxHeld
  } rx_state_e;

  typedef struct packed {
    logic       frame_ready;
    tick_t      address;
    logic [7:0] command;
    logic [7:0] key_code;
  } ird_report_t;

  // commands that map to a key
  localparam logic [7:0] CmdStop  = 8'd1;
  localparam logic [7:0] CmdWalk  = 8'd2;
  localparam logic [7:0] CmdTurn  = 8'd3;
  localparam logic [7:0] CmdSlow  = 8'd4;
  localparam logic [7:0] CmdFast  = 8'd5;

  // mirror of the decoder state
  cfg_t        win;
  tick_t       last_edge;
  tick_t       pulse_len;
  tick_t       pause_len;
  rx_state_e   rx_state;
  logic [4:0]  bit_cnt;
  logic [31:0] frame;

  ird_report_t report_q[$];

  function automatic logic between(tick_t v, tick_t lo, tick_t hi);
    return v > lo && v < hi;
  endfunction

  // strict window compare of the latest pulse and pause
  function automatic sym_e classify_pair();
    if (between(pulse_len, win.bit_pulse_min, win.bit_pulse_max)) begin
      if (between(pause_len, win.zero_pause_min, win.zero_pause_max)) return SymZero;
      if (between(pause_len, win.one_pause_min, win.one_pause_max)) return SymOne;
      return SymNone;
    end
    if (between(pulse_len, win.start_pulse_min, win.start_pulse_max)) begin
      if (between(pause_len, StartPauseMin, StartPauseMax)) return SymStart;
      if (between(pause_len, RepeatPauseMin, RepeatPauseMax)) return SymRepeat;
    end
    return SymNone;
  endfunction

  // receive sequencer
  function automatic void take_symbol(sym_e s);
    if (s == SymNone || rx_state == RxHeld) return;
    if (rx_state != RxBusy) begin
      rx_state = RxIdle;
      if (s == SymStart) begin
        bit_cnt  = '0;
        rx_state = RxBusy;
      end
      return;
    end
    if (s == SymStart || s == SymRepeat) begin
      bit_cnt = '0;
      return;
    end
    frame[bit_cnt] = (s == SymOne);
    bit_cnt = bit_cnt + 5'd1;
    if (bit_cnt == '0) begin
      rx_state = ((frame[23:16] ^ frame[31:24]) == 8'hff) ? RxHeld : RxIdle;
    end
  endfunction

  function automatic logic [7:0] key_for(logic [7:0] cmd);
    case (cmd)
      CmdStop: return KeyS;
      CmdWalk: return KeyW;
      CmdTurn: return KeyT;
      CmdSlow: return KeyMinus;
      CmdFast: return KeyPlus;
      default: return KeyNone;
    endcase
  endfunction

  // one request in, the report it produces out
  function automatic ird_report_t decode_request(ird_op_e op, tick_t t, logic lvl);
    ird_report_t rep;
    tick_t       delta;
    logic        show;
    logic [7:0]  key;
    show = 1'b0;
    key  = KeyNone;
    if (op == OpEdge) begin
      delta     = t - last_edge;
      last_edge = t;
      if (lvl) begin
        pulse_len = delta;
      end else begin
        pause_len = delta;
        take_symbol(classify_pair());
      end
    end else if (rx_state == RxHeld) begin
      key      = key_for(frame[23:16]);
      rx_state = RxIdle;
      show     = 1'b1;
    end
    if (rx_state == RxHeld) show = 1'b1;
    rep.frame_ready = (rx_state == RxHeld);
    rep.address     = show ? {frame[7:0], frame[15:8]} : '0;
    rep.command     = show ? frame[23:16] : '0;
    rep.key_code    = key;
    return rep;
  endfunction

  // snoop config, predict on each request, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin
    ird_report_t want;
    ird_report_t got;
    if (!rst_ni) begin
      win       = CfgReset;
      last_edge = '0;
      pulse_len = '0;
      pause_len = '0;
      rx_state  = RxIdle;
      bit_cnt   = '0;
      frame     = '0;
      report_q.delete();
      err_cnt_o = 0;
      in_flight_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBitPulseMin:   win.bit_pulse_min   = cfg_wdata_i;
          CfgBitPulseMax:   win.bit_pulse_max   = cfg_wdata_i;
          CfgZeroPauseMin:  win.zero_pause_min  = cfg_wdata_i;
          CfgZeroPauseMax:  win.zero_pause_max  = cfg_wdata_i;
          CfgOnePauseMin:   win.one_pause_min   = cfg_wdata_i;
          CfgOnePauseMax:   win.one_pause_max   = cfg_wdata_i;
          CfgStartPulseMin: win.start_pulse_min = cfg_wdata_i;
          CfgStartPulseMax: win.start_pulse_max = cfg_wdata_i;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        report_q.push_back(decode_request(ird_op_e'(req_i.op), req_i.capture_time,
                                          req_i.line_level));
      end
      if (res_i.valid && res_i.ready) begin
        got.frame_ready = res_i.frame_ready;
        got.address     = res_i.address;
        got.command     = res_i.command;
        got.key_code    = res_i.key_code;
        if (report_q.size() == 0) begin
          $error("result with no request pending");
          err_cnt_o++;
        end else begin
          want = report_q.pop_front();
          if (got.frame_ready !== want.frame_ready) begin
            $error("frame_ready: expected %0d, got %0d", want.frame_ready, got.frame_ready);
            err_cnt_o++;
          end
          if (got.address !== want.address) begin
            $error("address: expected %04h, got %04h", want.address, got.address);
            err_cnt_o++;
          end
          if (got.command !== want.command) begin
            $error("command: expected %02h, got %02h", want.command, got.command);
            err_cnt_o++;
          end
          if (got.key_code !== want.key_code) begin
            $error("key_code: expected %02h, got %02h", want.key_code, got.key_code);
            err_cnt_o++;
          end
        end
      end
      in_flight_o <= report_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
module tb import ird_pkg::*, ird_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HangLimit = 4000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  tick_t              cfg_wdata;
  int                 err_cnt;
  int                 in_flight;
  int                 hang_cnt;
  int                 item_cnt = 0;
  logic               calm = 1'b0;
  tick_t              now = '0;
  cfg_t               cur = CfgReset;
  int                 phase_end[6] = '{500, 900, 1150, 1300, 1550, 1850};

  ird_req_if req_if ();
  ird_res_if res_if ();

  ir_remote_frame_decoder_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  ird_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_i       (res_if),
    .err_cnt_o   (err_cnt),
    .in_flight_o (in_flight)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side back-pressure
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(99) < 8) begin
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // hang detection: cycles without any handshake
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hang_cnt <= 0;
    end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      hang_cnt <= 0;
    end else if (hang_cnt == HangLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  // one request, held until taken
  task automatic send_req(ird_op_e op, tick_t t, logic lvl);
    calm = item_cnt >= 600 && item_cnt < 900;
    if (!calm && $urandom_range(99) < 8) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.capture_time <= t;
    req_if.line_level   <= lvl;
    do @(posedge clk); while (!req_if.ready);
    item_cnt++;
  endtask

  // pulse then pause, as two line edges
  task automatic send_sym(tick_t pulse, tick_t pause);
    now = now + pulse;
    send_req(OpEdge, now, 1'b1);
    now = now + pause;
    send_req(OpEdge, now, 1'b0);
  endtask

  // value strictly inside a nonempty window, sometimes right on a bound
  function automatic tick_t in_window(tick_t lo, tick_t hi, logic rough);
    int unsigned r;
    r = $urandom_range(99);
    if (rough && r < 5) return lo;
    if (rough && r < 10) return hi;
    if (int'(hi) > int'(lo) + 1) return tick_t'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    return tick_t'($urandom);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, tick_t val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_cfg(cfg_t c);
    write_reg(CfgBitPulseMin, c.bit_pulse_min);
    write_reg(CfgBitPulseMax, c.bit_pulse_max);
    write_reg(CfgZeroPauseMin, c.zero_pause_min);
    write_reg(CfgZeroPauseMax, c.zero_pause_max);
    write_reg(CfgOnePauseMin, c.one_pause_min);
    write_reg(CfgOnePauseMax, c.one_pause_max);
    write_reg(CfgStartPulseMin, c.start_pulse_min);
    write_reg(CfgStartPulseMax, c.start_pulse_max);
    cfg_we <= 1'b0;
    cur = c;
  endtask

  // stop sending and let every result drain
  task automatic settle();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  // timing windows per phase: plausible, wide open, shut, arbitrary, default
  function automatic cfg_t pick_cfg(int phase);
    cfg_t c;
    c = CfgReset;
    case (phase)
      1: begin
        c.bit_pulse_min   = tick_t'($urandom_range(200, 500));
        c.bit_pulse_max   = c.bit_pulse_min + tick_t'($urandom_range(2, 400));
        c.zero_pause_min  = tick_t'($urandom_range(200, 500));
        c.zero_pause_max  = c.zero_pause_min + tick_t'($urandom_range(2, 400));
        c.one_pause_min   = tick_t'($urandom_range(1000, 1400));
        c.one_pause_max   = c.one_pause_min + tick_t'($urandom_range(2, 600));
        c.start_pulse_min = tick_t'($urandom_range(7000, 8800));
        c.start_pulse_max = c.start_pulse_min + tick_t'($urandom_range(2, 1500));
      end
      2: c = '{default: '0, bit_pulse_max: '1, zero_pause_max: '1, one_pause_max: '1,
               start_pulse_max: '1};
      3: c = '{default: '1, bit_pulse_max: '0, zero_pause_max: '0, one_pause_max: '0,
               start_pulse_max: '0};
      4: c = cfg_t'({$urandom, $urandom, $urandom, $urandom});
      default: c = CfgReset;
    endcase
    return c;
  endfunction

  // start burst, 32 bits, then maybe edges while held and an acknowledge
  task automatic send_frame();
    logic [31:0] bits;
    logic [7:0]  cmd;
    logic        rough;
    int          r;
    rough = $urandom_range(99) < 20;
    cmd   = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom);
    bits  = {~cmd, cmd, 16'($urandom)};
    if ($urandom_range(99) < 15) bits[31:24] = 8'($urandom);
    send_sym(in_window(cur.start_pulse_min, cur.start_pulse_max, rough),
             in_window(StartPauseMin, StartPauseMax, rough));
    for (int i = 0; i < 32; i++) begin
      if (rough && $urandom_range(99) < 3) send_sym(16'($urandom), 16'($urandom));
      send_sym(in_window(cur.bit_pulse_min, cur.bit_pulse_max, rough),
               bits[i] ? in_window(cur.one_pause_min, cur.one_pause_max, rough)
                       : in_window(cur.zero_pause_min, cur.zero_pause_max, rough));
    end
    r = $urandom_range(99);
    if (r < 30) begin
      repeat ($urandom_range(1, 4)) begin
        send_sym(in_window(cur.start_pulse_min, cur.start_pulse_max, 1'b0),
                 $urandom_range(1) ? in_window(StartPauseMin, StartPauseMax, 1'b0)
                                   : in_window(RepeatPauseMin, RepeatPauseMax, 1'b0));
      end
    end
    if (r < 85) send_req(OpAck, 16'($urandom), 1'($urandom));
  endtask

  // arbitrary edges and acknowledges at random times
  task automatic send_noise();
    tick_t t;
    repeat ($urandom_range(1, 6)) begin
      t = 16'($urandom);
      if ($urandom_range(99) < 15) begin
        send_req(OpAck, t, 1'($urandom));
      end else begin
        now = t;
        send_req(OpEdge, t, 1'($urandom));
      end
    end
  endtask

  task automatic random_scenario();
    int r;
    r = $urandom_range(99);
    if (r < 65) begin
      send_frame();
    end else if (r < 75) begin
      send_sym(in_window(cur.start_pulse_min, cur.start_pulse_max, 1'b1),
               in_window(RepeatPauseMin, RepeatPauseMax, 1'b1));
    end else if (r < 82) begin
      send_req(OpAck, 16'($urandom), 1'($urandom));
    end else begin
      send_noise();
    end
  endtask

  // bounds and corner cases under the default windows
  task automatic run_directed();
    // acknowledge with nothing held, time and level ignored
    send_req(OpAck, 16'hffff, 1'b1);
    send_req(OpAck, 16'h0000, 1'b0);
    // repeat burst while idle is dropped
    send_sym(16'd9000, 16'd2200);
    // pulse right on the bit window bounds
    send_sym(16'd400, 16'd500);
    send_sym(16'd700, 16'd500);
    // pause right on the zero window lower bound
    send_sym(16'd401, 16'd400);
    // valid zero while idle
    send_sym(16'd699, 16'd699);
    // start pulse on its bound, then a real start and two bits
    send_sym(16'd8500, 16'd4500);
    send_sym(16'd9499, 16'd4001);
    send_sym(16'd500, 16'd600);
    send_sym(16'd500, 16'd1899);
    // repeat and start while receiving restart the bit count
    send_sym(16'd8501, 16'd2499);
    send_sym(16'd9000, 16'd4999);
    // pause right on the one window lower bound
    send_sym(16'd500, 16'd1500);
  endtask

  // reset, directed part, then random phases with new windows
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CfgBitPulseMin;
    cfg_wdata           = '0;
    req_if.valid        = 1'b0;
    req_if.op           = OpEdge;
    req_if.capture_time = '0;
    req_if.line_level   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        settle();
        apply_cfg(pick_cfg(p));
      end
      while (item_cnt < phase_end[p]) random_scenario();
    end
    settle();
    if (err_cnt == 0 && in_flight == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
